FILE: hw/rtl/homogeneous_point_transform_defines.svh
// assertion macros shared by the point transform rtl
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define HPT_ASSERT(lbl, prop, msg)
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

  localparam int XW = 32;           // coordinate and matrix entry width
  localparam int SW = 66;           // exact column sum width
  localparam int QW = 33;           // quotient bits produced by the divider chain
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [QW-1:0] POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [QW-1:0] NEG_LIM = 33'h0_8000_0000;

  typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] hpt_cfg_t;

  // control travelling with one beat down the chain
  typedef struct packed {
    logic       vld;
    logic       wz;
    logic [2:0] neg;
    logic [2:0] ovf;
  } hpt_ctl_t;

  typedef struct packed {
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic signed [XW-1:0] out_z;
    logic                 w_was_zero;
    logic                 saturated;
  } hpt_res_t;

  function automatic logic signed [XW-1:0] mat_entry(hpt_cfg_t m, int r, int c);
    logic [CFG_DATA_W-1:0] reg_v;
    reg_v = m[2*r + (c >> 1)];
    return (c & 1) != 0 ? reg_v[63:32] : reg_v[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hpt_ifs.sv
`default_nettype none
interface hpt_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic              w_was_zero;
  logic              saturated;
  modport source (output valid, out_x, out_y, out_z, w_was_zero, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, w_was_zero, saturated, output ready);
endinterface

interface hpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hpt_front.sv
`default_nettype none
module hpt_front import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CW = SW + QW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 in_vld_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic signed [XW-1:0] z_i,
  input  wire hpt_cfg_t             mat_i,
  output hpt_ctl_t                  ctl_o,
  output logic [CW-1:0]             rem_o [3],
  output logic [SW-1:0]             den_o
);

  logic signed [2*XW-1:0] prod_q [4][3];
  logic signed [XW-1:0]   trans_q [4];
  logic                   vld1_q, vld2_q;
  logic signed [SW-1:0]   sum_q [4];
  logic signed [XW-1:0]   pt [3];

  logic                   wz;
  logic                   den_neg;
  logic [SW-1:0]          den;
  logic [SW-1:0]          mag [3];
  logic [CW-1:0]          num [3];
  logic [CW-1:0]          den_sh;
  hpt_ctl_t               ctl_d;
  logic                   vld3_q;
  logic                   wz_q;
  logic [2:0]             neg_q;
  logic [2:0]             ovf_q;
  logic [CW-1:0]          rem_q [3];
  logic [SW-1:0]          den_q;

  assign pt[0] = x_i;
  assign pt[1] = y_i;
  assign pt[2] = z_i;

  // products of the point with each column
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= (2*XW)'(pt[r]) * (2*XW)'(mat_entry(mat_i, r, c));
        end
        trans_q[c] <= mat_entry(mat_i, 3, c);
      end
    end
  end

  // exact column sums
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SW'(prod_q[c][0]) + SW'(prod_q[c][1]) + SW'(prod_q[c][2])
                    + (SW'(trans_q[c]) <<< FRAC_BITS);
      end
    end
  end

  // divisor, magnitudes, signs and the too-large check
  always_comb begin
    wz      = (sum_q[3] == '0);
    den_neg = !wz && sum_q[3][SW-1];
    if (wz) begin
      den = SW'(1) << (2*FRAC_BITS);
    end else begin
      den = sum_q[3][SW-1] ? SW'(-sum_q[3]) : SW'(sum_q[3]);
    end
    den_sh    = CW'(den) << QW;
    ctl_d.vld = vld2_q;
    ctl_d.wz  = wz;
    for (int c = 0; c < 3; c++) begin
      mag[c]        = sum_q[c][SW-1] ? SW'(-sum_q[c]) : SW'(sum_q[c]);
      num[c]        = CW'(mag[c]) << FRAC_BITS;
      ctl_d.neg[c]  = sum_q[c][SW-1] != den_neg;
      ctl_d.ovf[c]  = num[c] >= den_sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= num[c];
      end
      den_q <= den;
      wz_q  <= ctl_d.wz;
      neg_q <= ctl_d.neg;
      ovf_q <= ctl_d.ovf;
    end
  end

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= in_vld_i;
      vld2_q <= vld1_q;
      vld3_q <= ctl_d.vld;
    end
  end

  assign ctl_o = '{vld: vld3_q, wz: wz_q, neg: neg_q, ovf: ovf_q};
  assign rem_o = rem_q;
  assign den_o = den_q;

endmodule
`default_nettype wire

FILE: hw/rtl/hpt_div_cell.sv
`default_nettype none
`include "homogeneous_point_transform_defines.svh"
module hpt_div_cell import hpt_pkg::*; #(
  parameter int CW = SW + QW,
  parameter int K = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire hpt_ctl_t      ctl_i,
  input  wire logic [CW-1:0] rem_i [3],
  input  wire logic [QW-1:0] q_i [3],
  input  wire logic [SW-1:0] den_i,
  output hpt_ctl_t           ctl_o,
  output logic [CW-1:0]      rem_o [3],
  output logic [QW-1:0]      q_o [3],
  output logic [SW-1:0]      den_o
);

  logic [CW-1:0] den_sh;
  logic [CW:0]   diff [3];
  logic [CW-1:0] rem_d [3];
  logic [QW-1:0] q_d [3];
  logic          vld_q;
  logic          wz_q;
  logic [2:0]    neg_q;
  logic [2:0]    ovf_q;
  logic [CW-1:0] rem_q [3];
  logic [QW-1:0] q_q [3];
  logic [SW-1:0] den_q;
  logic [CW-1:0] chk_sh;

  // one restoring step per lane: quotient bit K
  always_comb begin
    den_sh = CW'(den_i) << K;
    for (int l = 0; l < 3; l++) begin
      diff[l]  = {1'b0, rem_i[l]} - {1'b0, den_sh};
      rem_d[l] = diff[l][CW] ? rem_i[l] : diff[l][CW-1:0];
      q_d[l]   = q_i[l] | (QW'(!diff[l][CW]) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
      den_q <= den_i;
      wz_q  <= ctl_i.wz;
      neg_q <= ctl_i.neg;
      ovf_q <= ctl_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  assign ctl_o = '{vld: vld_q, wz: wz_q, neg: neg_q, ovf: ovf_q};
  assign rem_o = rem_q;
  assign q_o   = q_q;
  assign den_o = den_q;

  assign chk_sh = CW'(den_q) << K;

  // remainder stays below the divisor weight just processed
  `HPT_ASSERT_IMPL(a_rem0, vld_q && !ovf_q[0], rem_q[0] < chk_sh, "lane 0 remainder")
  `HPT_ASSERT_IMPL(a_rem1, vld_q && !ovf_q[1], rem_q[1] < chk_sh, "lane 1 remainder")
  `HPT_ASSERT_IMPL(a_rem2, vld_q && !ovf_q[2], rem_q[2] < chk_sh, "lane 2 remainder")
  `HPT_ASSERT(a_vld_move, adv_i |=> (vld_q == $past(ctl_i.vld)), "valid lost in cell")

endmodule
`default_nettype wire

FILE: hw/rtl/homogeneous_point_transform.sv
`default_nettype none
`include "homogeneous_point_transform_defines.svh"
// Transforms a point (x, y, z, 1) by the configured 4x4 matrix and divides
// x, y, z by w, all in signed fixed point with FRAC_BITS fraction bits. One
// point is accepted and one result leaves per cycle unless output stalls;
// stages are multiply, column sum, divisor setup, 33 divider cells each
// settling one quotient bit for all three lanes, and the saturating output
// register. Backpressure stalls the whole chain at once. The user must write
// matrix registers through the config channel while no point is in flight;
// unenforced by the block; indexes beyond the eighth register are ignored.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hpt_in_if.sink    in_ch,
  hpt_out_if.source out_ch,
  hpt_cfg_if.sink   cfg_ch
);

  localparam int CW = SW + QW;
  localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (FRAC_BITS + 32);
  localparam logic [CFG_DATA_W-1:0] ZERO_REG = '0;
  // identity matrix, register 7 first
  localparam hpt_cfg_t MAT_RST = {ONE_HI, ZERO_REG, ONE_LO, ZERO_REG,
                                  ZERO_REG, ONE_HI, ZERO_REG, ONE_LO};

  hpt_cfg_t      mat_q;
  logic          adv;
  hpt_ctl_t      ctl_s [QW+1];
  logic [CW-1:0] rem_s [QW+1][3];
  logic [QW-1:0] q_s [QW+1][3];
  logic [SW-1:0] den_s [QW+1];
  hpt_res_t      res_d, res_q;
  logic          out_vld_q;
  logic [2:0]    lane_sat;
  logic signed [XW-1:0] lane_val [3];

  // matrix registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MAT_RST;
    end else if (cfg_ch.valid && cfg_ch.index < CFG_IDX_W'(NUM_REGS)) begin
      mat_q[cfg_ch.index[$clog2(NUM_REGS)-1:0]] <= cfg_ch.data;
    end
  end

  // chain advances whenever the output register can take a beat
  assign adv         = !out_vld_q || out_ch.ready;
  assign in_ch.ready = adv;

  hpt_front #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_front (
    .clk_i, .rst_ni, .adv_i(adv), .in_vld_i(in_ch.valid),
    .x_i(in_ch.in_x), .y_i(in_ch.in_y), .z_i(in_ch.in_z), .mat_i(mat_q),
    .ctl_o(ctl_s[0]), .rem_o(rem_s[0]), .den_o(den_s[0])
  );

  assign q_s[0][0] = '0;
  assign q_s[0][1] = '0;
  assign q_s[0][2] = '0;

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    hpt_div_cell #(.CW(CW), .K(QW - 1 - i)) u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .ctl_i(ctl_s[i]), .rem_i(rem_s[i]), .q_i(q_s[i]), .den_i(den_s[i]),
      .ctl_o(ctl_s[i+1]), .rem_o(rem_s[i+1]), .q_o(q_s[i+1]), .den_o(den_s[i+1])
    );
  end

  // sign and saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (ctl_s[QW].neg[c]) begin
        lane_sat[c] = ctl_s[QW].ovf[c] || (q_s[QW][c] > NEG_LIM);
        lane_val[c] = lane_sat[c] ? XW'(NEG_LIM) : XW'(-q_s[QW][c]);
      end else begin
        lane_sat[c] = ctl_s[QW].ovf[c] || (q_s[QW][c] > POS_LIM);
        lane_val[c] = lane_sat[c] ? XW'(POS_LIM) : q_s[QW][c][XW-1:0];
      end
    end
    res_d.out_x      = lane_val[0];
    res_d.out_y      = lane_val[1];
    res_d.out_z      = lane_val[2];
    res_d.w_was_zero = ctl_s[QW].wz;
    res_d.saturated  = |lane_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctl_s[QW].vld;
    end
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.out_x      = res_q.out_x;
  assign out_ch.out_y      = res_q.out_y;
  assign out_ch.out_z      = res_q.out_z;
  assign out_ch.w_was_zero = res_q.w_was_zero;
  assign out_ch.saturated  = res_q.saturated;

  `HPT_ASSERT_IMPL(a_empty_ready, !out_vld_q, in_ch.ready, "empty output blocks input")
  `HPT_ASSERT_IMPL(a_sat_bound, out_vld_q && res_q.saturated,
    res_q.out_x == XW'(POS_LIM) || res_q.out_x == XW'(NEG_LIM) ||
    res_q.out_y == XW'(POS_LIM) || res_q.out_y == XW'(NEG_LIM) ||
    res_q.out_z == XW'(POS_LIM) || res_q.out_z == XW'(NEG_LIM), "saturated without bound")
  `HPT_ASSERT(a_stall_hold, !adv |=> (out_vld_q && $stable(res_q)), "stalled result moved")

endmodule
`default_nettype wire
